/* design/tcf_pkg.sv */
// shared constants, state codes and arctangent table for the tilt complementary filter
`default_nettype none

package tcf_pkg;

   // datapath widths that do not follow the angle format
   localparam int CW        = 27;  // cordic x and y, accel counts scaled by 2^8 plus gain headroom
   localparam int ZW        = 25;  // cordic angle, degrees with 16 fraction bits
   localparam int BW        = 18;  // multiplier coefficient operand, signed
   localparam int ACC_GUARD = 8;
   localparam int TBL_LEN   = 24;
   localparam int TBL_IW    = 5;
   localparam int OUT_W     = 17;
   localparam int IN_W      = 16;

   localparam int ANGLE_LIMIT_DEG = 180;
   localparam logic [15:0] INV_GAIN = 16'd39797;  // 1/K in Q0.16

   // configuration port
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 16;
   localparam logic [CSR_IW-1:0] REG_BLEND_WEIGHT = 2'd0;
   localparam logic [CSR_IW-1:0] REG_TIME_STEP    = 2'd1;
   localparam logic [CSR_DW-1:0] BLEND_WEIGHT_RESET = 16'd19661;
   localparam logic [CSR_DW-1:0] TIME_STEP_RESET    = 16'd655;

   // sequencer
   typedef logic [3:0] state_type;
   localparam state_type S_IDLE = 4'd0;
   localparam state_type S_MAG  = 4'd1;   // magnitude vectoring
   localparam state_type S_G0   = 4'd2;   // gain multiply, pitch lane
   localparam state_type S_G1   = 4'd3;   // gain multiply, roll lane
   localparam state_type S_G2   = 4'd4;   // reload roll lane
   localparam state_type S_ANG  = 4'd5;   // angle vectoring
   localparam state_type S_B0   = 4'd6;
   localparam state_type S_B1   = 4'd7;
   localparam state_type S_B2   = 4'd8;
   localparam state_type S_B3   = 4'd9;
   localparam state_type S_B4   = 4'd10;
   localparam state_type S_B5   = 4'd11;
   localparam state_type S_B6   = 4'd12;

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic signed [ZW-1:0] atan_deg(input logic [TBL_IW-1:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:    v = 25'sd2949120;
         5'd1:    v = 25'sd1740967;
         5'd2:    v = 25'sd919879;
         5'd3:    v = 25'sd466945;
         5'd4:    v = 25'sd234379;
         5'd5:    v = 25'sd117304;
         5'd6:    v = 25'sd58666;
         5'd7:    v = 25'sd29335;
         5'd8:    v = 25'sd14668;
         5'd9:    v = 25'sd7334;
         5'd10:   v = 25'sd3667;
         5'd11:   v = 25'sd1833;
         5'd12:   v = 25'sd917;
         5'd13:   v = 25'sd458;
         5'd14:   v = 25'sd229;
         5'd15:   v = 25'sd115;
         5'd16:   v = 25'sd57;
         5'd17:   v = 25'sd29;
         5'd18:   v = 25'sd14;
         5'd19:   v = 25'sd7;
         5'd20:   v = 25'sd4;
         5'd21:   v = 25'sd2;
         5'd22:   v = 25'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* design/tilt_complementary_filter.sv */
// tilt complementary filter top level: cordic tilt angles, gyro integration and blend
`default_nettype none

// Takes one IMU beat (three accelerometer axes, two gyro rates) and returns one beat with
// the filtered pitch and roll in degrees, ANGLE_FRAC_BITS fraction bits, saturated at
// +-180 and sent as 17-bit two's complement. Pitch = atan(x/sqrt(y^2+z^2)) and
// roll = atan(y/sqrt(x^2+z^2)) come from two cordic lanes that run side by side: one
// vectoring pass gives the root, a gain multiply corrects it, a second pass gives the
// angle. The kept angles are advanced by gyro rate times time_step and blended as
// k*accel + (1-k)*gyro. The cordic iteration loop sets most of the time that one item
// occupies the block, and the single shared multiplier handles the gain, gyro and blend
// products one per cycle. req_stall is high from acceptance until the result is written
// to the output register; a finished result waits there while the next beat is already
// being worked. The user is to write blend_weight (index 0) and time_step (index 1) only
// while idle; the block itself does not enforce this.
module tilt_complementary_filter
   import tcf_pkg::*;
#(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   // configuration writes
   input  wire                      csr_write,
   input  wire [CSR_IW-1:0]         csr_index,
   input  wire [CSR_DW-1:0]         csr_wdata,
   // sample beats in
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire signed [IN_W-1:0]    req_acc_x,
   input  wire signed [IN_W-1:0]    req_acc_y,
   input  wire signed [IN_W-1:0]    req_acc_z,
   input  wire signed [IN_W-1:0]    req_gyro_x,
   input  wire signed [IN_W-1:0]    req_gyro_y,
   // angle beats out
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic signed [OUT_W-1:0]  rsp_pitch_out,
   output logic signed [OUT_W-1:0]  rsp_roll_out
);

   // effective iteration count, the atan table has 24 entries
   localparam int STEPS = (CORDIC_STEPS < TBL_LEN) ? CORDIC_STEPS : TBL_LEN;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

   localparam int F   = ANGLE_FRAC_BITS;
   localparam int AGW = F + 9;           // kept angle, holds +-180 degrees
   localparam int GW  = F + 13;          // angle plus gyro increment
   localparam int AW  = (CW > GW) ? CW : GW;
   localparam int PW  = AW + BW;         // product
   localparam int SW  = PW + 1;          // blend sum
   localparam int EW  = (AGW > OUT_W) ? AGW : OUT_W;
   localparam int LANES = 2;             // lane 0 pitch, lane 1 roll

   localparam logic signed [AGW-1:0] ANGLE_LIM  = AGW'(ANGLE_LIMIT_DEG << F);
   localparam logic signed [AGW-1:0] ANGLE_NLIM = -ANGLE_LIM;
   localparam logic signed [SW-1:0]  LIM_W      = SW'(ANGLE_LIMIT_DEG << F);
   localparam logic signed [SW-1:0]  NLIM_W     = -LIM_W;
   localparam logic signed [SW-1:0]  BLEND_RND  = SW'(32768);
   localparam logic signed [PW-1:0]  GAIN_RND   = PW'(32768);
   localparam logic signed [PW+F-1:0] INC_RND   = (PW + F)'(1 << 19);
   localparam logic signed [ZW-1:0]  ZROUND     = ZW'(1 << (15 - F));

   // control state
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff;
   logic                    load_rsp;
   logic [CSR_DW-1:0]       blend_weight_ff;
   logic [CSR_DW-1:0]       time_step_ff;
   logic signed [AGW-1:0]   ang_ff [LANES];  // kept filtered angles

   // cordic lanes
   logic signed [CW-1:0]    x_ff [LANES];
   logic signed [CW-1:0]    y_ff [LANES];
   logic signed [ZW-1:0]    z_ff [LANES];
   logic signed [CW-1:0]    xs_c [LANES];
   logic signed [CW-1:0]    ys_c [LANES];
   logic signed [CW-1:0]    x_step [LANES];
   logic signed [CW-1:0]    y_step [LANES];
   logic signed [ZW-1:0]    z_step [LANES];
   logic signed [ZW-1:0]    tz_c;

   // per-item operands
   logic signed [IN_W-1:0]  num_ff [LANES];
   logic signed [IN_W-1:0]  gyro_ff [LANES];
   logic                    zero_ff [LANES];

   // shared multiplier and blend path
   logic signed [AW-1:0]    mul_a;
   logic signed [BW-1:0]    mul_b;
   logic signed [PW-1:0]    mul_p;
   logic signed [PW-1:0]    prod_ff;
   logic signed [PW-1:0]    sum_ff;
   logic signed [GW-1:0]    g_ff [LANES];
   logic signed [GW-1:0]    g_c;
   logic signed [AGW-1:0]   acc_c [LANES];
   logic signed [ZW-1:0]    zr_c [LANES];
   logic signed [PW-1:0]    gain_sum;
   logic signed [CW-1:0]    root_c;
   logic signed [PW+F-1:0]  inc_wide;
   logic signed [GW-1:0]    inc_c;
   logic [16:0]             one_minus_k;
   logic signed [SW-1:0]    blend_sum;
   logic signed [SW-1:0]    blend_shr;
   logic signed [AGW-1:0]   blend_c;
   logic signed [EW-1:0]    pitch_ext;
   logic signed [EW-1:0]    roll_ext;
   logic signed [OUT_W-1:0] rsp_pitch_ff;
   logic signed [OUT_W-1:0] rsp_roll_ff;

   // |v| << 8 as a cordic operand
   function automatic logic signed [CW-1:0] scaled_abs(input logic signed [IN_W-1:0] v);
      logic signed [IN_W:0] e;
      logic [IN_W:0]        m;
      e = (IN_W + 1)'(v);
      m = e[IN_W] ? -e : e;
      return $signed(CW'({m, 8'd0}));
   endfunction

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pitch_out = rsp_pitch_ff;
   assign rsp_roll_out  = rsp_roll_ff;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      load_rsp = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_MAG;
               cnt_in   = '0;
            end
         end
         S_MAG: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = S_G0;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_G0: state_in = S_G1;
         S_G1: state_in = S_G2;
         S_G2: begin
            state_in = S_ANG;
            cnt_in   = '0;
         end
         S_ANG: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = S_B0;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_B0: state_in = S_B1;
         S_B1: state_in = S_B2;
         S_B2: state_in = S_B3;
         S_B3: state_in = S_B4;
         S_B4: state_in = S_B5;
         S_B5: state_in = S_B6;
         S_B6: begin
            // hold here while the previous result is still stalled in the output register
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // one cordic vectoring step on both lanes, shift amount is the step count
   // ---------------------------------------------------------------------
   assign tz_c = atan_deg(TBL_IW'(cnt_ff));

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         xs_c[l] = x_ff[l] >>> cnt_ff;
         ys_c[l] = y_ff[l] >>> cnt_ff;
         if (y_ff[l][CW-1]) begin
            x_step[l] = x_ff[l] - ys_c[l];
            y_step[l] = y_ff[l] + xs_c[l];
            z_step[l] = z_ff[l] - tz_c;
         end else begin
            x_step[l] = x_ff[l] + ys_c[l];
            y_step[l] = y_ff[l] - xs_c[l];
            z_step[l] = z_ff[l] + tz_c;
         end
      end
   end

   // accel angle rounded half up to F fraction bits, zero when the root is zero
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         zr_c[l]  = (z_ff[l] + ZROUND) >>> (16 - F);
         acc_c[l] = zero_ff[l] ? '0 : zr_c[l][AGW-1:0];
      end
   end

   // gain corrected root from the last product
   assign gain_sum = prod_ff + GAIN_RND;
   assign root_c   = gain_sum[CW+15:16];

   // ---------------------------------------------------------------------
   // shared multiplier operand select
   // ---------------------------------------------------------------------
   assign one_minus_k = 17'h10000 - {1'b0, blend_weight_ff};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_G0: begin
            mul_a = AW'(x_ff[0]);
            mul_b = $signed(BW'(INV_GAIN));
         end
         S_G1: begin
            mul_a = AW'(x_ff[1]);
            mul_b = $signed(BW'(INV_GAIN));
         end
         S_B0: begin
            mul_a = AW'(gyro_ff[0]);
            mul_b = $signed(BW'(time_step_ff));
         end
         S_B1: begin
            mul_a = AW'(gyro_ff[1]);
            mul_b = $signed(BW'(time_step_ff));
         end
         S_B2: begin
            mul_a = AW'(acc_c[0]);
            mul_b = $signed(BW'(blend_weight_ff));
         end
         S_B3: begin
            mul_a = AW'(g_ff[0]);
            mul_b = $signed(BW'(one_minus_k));
         end
         S_B4: begin
            mul_a = AW'(acc_c[1]);
            mul_b = $signed(BW'(blend_weight_ff));
         end
         S_B5: begin
            mul_a = AW'(g_ff[1]);
            mul_b = $signed(BW'(one_minus_k));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PW'(mul_a) * PW'(mul_b);

   // gyro increment: gyro*dt*2^F / 2^20, rounded half up, added to the kept angle
   assign inc_wide = ((PW + F)'(prod_ff) <<< F) + INC_RND;
   assign inc_c    = inc_wide[GW+19:20];
   assign g_c      = GW'((state_ff == S_B2) ? ang_ff[1] : ang_ff[0]) + inc_c;

   // blend k*acc + (1-k)*gyro with rounding, then clamp to +-180 degrees
   assign blend_sum = SW'(sum_ff) + SW'(prod_ff) + BLEND_RND;
   assign blend_shr = blend_sum >>> 16;

   always_comb begin
      if (blend_shr > LIM_W) begin
         blend_c = ANGLE_LIM;
      end else if (blend_shr < NLIM_W) begin
         blend_c = ANGLE_NLIM;
      end else begin
         blend_c = blend_shr[AGW-1:0];
      end
   end

   assign pitch_ext = EW'(ang_ff[0]);
   assign roll_ext  = EW'(blend_c);

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         cnt_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         blend_weight_ff <= BLEND_WEIGHT_RESET;
         time_step_ff    <= TIME_STEP_RESET;
         ang_ff[0]       <= '0;
         ang_ff[1]       <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index)
               REG_BLEND_WEIGHT: blend_weight_ff <= csr_wdata;
               REG_TIME_STEP:    time_step_ff    <= csr_wdata;
               default:          ;
            endcase
         end
         // pitch settles in b4, roll when the result goes out
         if (state_ff == S_B4) begin
            ang_ff[0] <= blend_c;
         end
         if (load_rsp) begin
            ang_ff[1] <= blend_c;
         end
      end
   end

   // ---------------------------------------------------------------------
   // datapath registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // pitch lane takes root of (y, z), roll lane root of (x, z)
               x_ff[0]    <= scaled_abs(req_acc_y);
               y_ff[0]    <= scaled_abs(req_acc_z);
               x_ff[1]    <= scaled_abs(req_acc_x);
               y_ff[1]    <= scaled_abs(req_acc_z);
               z_ff[0]    <= '0;
               z_ff[1]    <= '0;
               num_ff[0]  <= req_acc_x;
               num_ff[1]  <= req_acc_y;
               zero_ff[0] <= (req_acc_y == '0) && (req_acc_z == '0);
               zero_ff[1] <= (req_acc_x == '0) && (req_acc_z == '0);
               gyro_ff[0] <= req_gyro_y;
               gyro_ff[1] <= req_gyro_x;
            end
         end
         S_MAG, S_ANG: begin
            for (int l = 0; l < LANES; l++) begin
               x_ff[l] <= x_step[l];
               y_ff[l] <= y_step[l];
               z_ff[l] <= z_step[l];
            end
         end
         S_G1: begin
            x_ff[0] <= root_c;
            y_ff[0] <= CW'(num_ff[0]) <<< ACC_GUARD;
            z_ff[0] <= '0;
         end
         S_G2: begin
            x_ff[1] <= root_c;
            y_ff[1] <= CW'(num_ff[1]) <<< ACC_GUARD;
            z_ff[1] <= '0;
         end
         S_B1: g_ff[0] <= g_c;
         S_B2: g_ff[1] <= g_c;
         S_B3: sum_ff  <= prod_ff;
         S_B5: sum_ff  <= prod_ff;
         default: ;
      endcase

      case (state_ff)
         S_G0, S_G1, S_B0, S_B1, S_B2, S_B3, S_B4, S_B5: prod_ff <= mul_p;
         default: ;
      endcase

      if (load_rsp) begin
         rsp_pitch_ff <= pitch_ext[OUT_W-1:0];
         rsp_roll_ff  <= roll_ext[OUT_W-1:0];
      end
   end

`ifndef SYNTHESIS
   a_accept_starts_root: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_MAG && cnt_ff == '0))
      else $error("accepted beat did not start the magnitude pass");

   a_angle_pass_from_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_G2) |=> (state_ff == S_ANG && cnt_ff == '0))
      else $error("angle pass did not start at step zero");

   a_result_from_blend: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_B6))
      else $error("result raised outside the final blend step");

   a_angles_in_range: assert property (@(posedge clock) disable iff (reset)
      (ang_ff[0] <= ANGLE_LIM && ang_ff[0] >= ANGLE_NLIM &&
       ang_ff[1] <= ANGLE_LIM && ang_ff[1] >= ANGLE_NLIM))
      else $error("kept angle beyond 180 degrees");
`endif

endmodule

`default_nettype wire

/* sim/tcf_angle_checker.sv */
// channel monitor with tilt angle prediction and result comparison for the tilt filter
module tcf_angle_checker
   import tcf_pkg::*;
#(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      csr_write,
   input  wire [CSR_IW-1:0]         csr_index,
   input  wire [CSR_DW-1:0]         csr_wdata,
   input  wire                      req_valid,
   input  wire                      req_stall,
   input  wire signed [IN_W-1:0]    req_acc_x,
   input  wire signed [IN_W-1:0]    req_acc_y,
   input  wire signed [IN_W-1:0]    req_acc_z,
   input  wire signed [IN_W-1:0]    req_gyro_x,
   input  wire signed [IN_W-1:0]    req_gyro_y,
   input  wire                      rsp_valid,
   input  wire                      rsp_stall,
   input  wire signed [OUT_W-1:0]   rsp_pitch_out,
   input  wire signed [OUT_W-1:0]   rsp_roll_out,
   output int                       mismatches,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     ATAN_LEN   = 24;
   localparam longint GAIN_COMP  = 39797;  // 1/K, 16 fraction bits
   localparam int     ACC_SHIFT  = 8;
   localparam longint ATAN_Q16 [ATAN_LEN] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef struct packed {
      logic signed [OUT_W-1:0] pitch;
      logic signed [OUT_W-1:0] roll;
   } angle_pair_type;

   angle_pair_type angle_q[$];
   angle_pair_type want;
   longint      blend_k;
   longint      step_dt;
   longint      pitch_state;
   longint      roll_state;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // vectoring pass, returns the angle and leaves the scaled magnitude in mag
   function automatic longint cordic_vector(input longint x0, input longint y0,
                                            output longint mag);
      longint x, y, z, xs, ys;
      int     n, i;
      x = x0;
      y = y0;
      z = 0;
      n = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
      for (i = 0; i < n; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y < 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_Q16[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_Q16[i];
         end
      end
      mag = x;
      return z;
   endfunction

   // atan(num / sqrt(a^2 + b^2)) in degrees, zero when the root vanishes
   function automatic longint tilt_deg(input longint num, input longint a, input longint b);
      longint kmag, r, z, unused;
      if (a == 0 && b == 0)
         return 0;
      z = cordic_vector(((a < 0) ? -a : a) <<< ACC_SHIFT,
                        ((b < 0) ? -b : b) <<< ACC_SHIFT, kmag);
      r = (kmag * GAIN_COMP + 32768) >>> 16;
      z = cordic_vector(r, num * 256, unused);
      return (z + (longint'(1) <<< (15 - ANGLE_FRAC_BITS))) >>> (16 - ANGLE_FRAC_BITS);
   endfunction

   // gyro integration, weighted mix and saturation
   function automatic longint fuse_angle(input longint prev, input longint rate,
                                         input longint acc);
      longint lim, inc, v;
      lim = longint'(ANGLE_LIMIT_DEG) <<< ANGLE_FRAC_BITS;
      inc = (rate * step_dt * (longint'(1) <<< ANGLE_FRAC_BITS) + (longint'(1) <<< 19)) >>> 20;
      v = (blend_k * acc + (65536 - blend_k) * (prev + inc) + 32768) >>> 16;
      if (v > lim)
         v = lim;
      if (v < -lim)
         v = -lim;
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         blend_k     = longint'(BLEND_WEIGHT_RESET);
         step_dt     = longint'(TIME_STEP_RESET);
         pitch_state = 0;
         roll_state  = 0;
         angle_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_BLEND_WEIGHT: blend_k = longint'(csr_wdata);
               REG_TIME_STEP:    step_dt = longint'(csr_wdata);
               default:          ;
            endcase
         end
         // results first, so a beat accepted at this edge cannot match early
         if (rsp_valid && !rsp_stall) begin
            if (angle_q.size() == 0) begin
               $error("unexpected angle beat: pitch_out %0d, roll_out %0d",
                      rsp_pitch_out, rsp_roll_out);
               mismatches++;
            end else begin
               want = angle_q.pop_front();
               if (rsp_pitch_out !== want.pitch) begin
                  $error("pitch_out: expected %0d, actual %0d", want.pitch, rsp_pitch_out);
                  mismatches++;
               end
               if (rsp_roll_out !== want.roll) begin
                  $error("roll_out: expected %0d, actual %0d", want.roll, rsp_roll_out);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pitch_state = fuse_angle(pitch_state, longint'(req_gyro_y),
                                     tilt_deg(longint'(req_acc_x), longint'(req_acc_y),
                                              longint'(req_acc_z)));
            roll_state  = fuse_angle(roll_state, longint'(req_gyro_x),
                                     tilt_deg(longint'(req_acc_y), longint'(req_acc_x),
                                              longint'(req_acc_z)));
            want.pitch = pitch_state[OUT_W-1:0];
            want.roll  = roll_state[OUT_W-1:0];
            angle_q.push_back(want);
         end
      end
      pending = angle_q.size();
   end

endmodule

/* sim/tb_top.sv */
// stimulus, clock, reset and verdict for the tilt complementary filter
module tb_top
   import tcf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int PHASE_BEATS     = 250;

   // indexes the block has no register behind, writes there must be dropped
   localparam logic [CSR_IW-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IW-1:0] REG_SPARE_3 = 2'd3;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write = 1'b0;
   logic [CSR_IW-1:0]       csr_index = '0;
   logic [CSR_DW-1:0]       csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [IN_W-1:0]  req_acc_x = '0;
   logic signed [IN_W-1:0]  req_acc_y = '0;
   logic signed [IN_W-1:0]  req_acc_z = '0;
   logic signed [IN_W-1:0]  req_gyro_x = '0;
   logic signed [IN_W-1:0]  req_gyro_y = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_pitch_out;
   logic signed [OUT_W-1:0] rsp_roll_out;

   int             mismatches;
   int             pending;
   int             burst_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   always #5 clock = ~clock;

   tilt_complementary_filter #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_acc_x     (req_acc_x),
      .req_acc_y     (req_acc_y),
      .req_acc_z     (req_acc_z),
      .req_gyro_x    (req_gyro_x),
      .req_gyro_y    (req_gyro_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pitch_out (rsp_pitch_out),
      .rsp_roll_out  (rsp_roll_out)
   );

   // watches both channels and the register port, predicts and compares
   tcf_angle_checker #(
      .CORDIC_STEPS    (CORDIC_STEPS),
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
   ) angle_monitor (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_acc_x     (req_acc_x),
      .req_acc_y     (req_acc_y),
      .req_acc_z     (req_acc_z),
      .req_gyro_x    (req_gyro_x),
      .req_gyro_y    (req_gyro_y),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pitch_out (rsp_pitch_out),
      .rsp_roll_out  (rsp_roll_out),
      .mismatches    (mismatches),
      .pending       (pending)
   );

   // receiver back-pressure: stretches of random length, each with its own stall density
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(1, 60);
      end else begin
         stall_left = stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HALF:  rsp_stall <= ($urandom_range(0, 1) == 0);
         default:     rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // one register write, then the enable is dropped before the task returns so it never drops and rises in one step
   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // present one sample beat and hold it until accepted; bursts end in a random gap
   task automatic send_sample(input logic signed [IN_W-1:0] ax, input logic signed [IN_W-1:0] ay,
                              input logic signed [IN_W-1:0] az, input logic signed [IN_W-1:0] gx,
                              input logic signed [IN_W-1:0] gy);
      req_valid  <= 1'b1;
      req_acc_x  <= ax;
      req_acc_y  <= ay;
      req_acc_z  <= az;
      req_gyro_x <= gx;
      req_gyro_y <= gy;
      do
         @(posedge clock);
      while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 30);
      end
   endtask

   // stop sending and let every outstanding angle beat come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);
   endtask

   // axis or rate value: rail values, zero and small tilts get extra weight
   function automatic logic signed [IN_W-1:0] random_axis();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 16'sh8000;
         2:       return 16'sh7fff;
         3, 4:    return IN_W'($urandom_range(0, 64) - 32);
         default: return IN_W'($urandom());
      endcase
   endfunction

   task automatic random_sample();
      logic signed [IN_W-1:0] ax, ay, az;
      ax = random_axis();
      ay = random_axis();
      az = random_axis();
      // force a vanishing root under one of the tilt angles now and then
      case ($urandom_range(0, 11))
         0:       begin ay = '0; az = '0; end
         1:       begin ax = '0; az = '0; end
         2:       begin ax = '0; ay = '0; end
         default: ;
      endcase
      send_sample(ax, ay, az, random_axis(), random_axis());
   endtask

   // one register setting followed by random beats, with an occasional full drain
   task automatic run_phase(input logic [CSR_DW-1:0] k, input logic [CSR_DW-1:0] dt);
      write_reg(REG_BLEND_WEIGHT, k);
      write_reg(REG_TIME_STEP, dt);
      repeat (PHASE_BEATS) begin
         random_sample();
         if ($urandom_range(0, 149) == 0)
            settle();
      end
      settle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed beats under the reset values of both registers
      send_sample('0, '0, '0, '0, '0);
      send_sample(16'sh7fff, '0, '0, '0, '0);          // pitch root vanishes
      send_sample(16'sh8000, '0, '0, '0, '0);
      send_sample('0, 16'sh7fff, '0, '0, '0);          // roll root vanishes
      send_sample('0, 16'sh8000, '0, '0, '0);
      send_sample('0, '0, 16'sh7fff, '0, '0);          // level, both numerators zero
      send_sample('0, '0, 16'sh8000, '0, '0);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1);
      send_sample(-16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd1);
      send_sample(16'sh7fff, 16'sh8000, '0, 16'sh7fff, 16'sh8000);
      send_sample('0, '0, 16'sd16384, 16'sd16, -16'sd16);
      send_sample(16'sd16384, '0, 16'sd16384, '0, '0);  // 45 degree pitch
      send_sample(16'sh8000, 16'sh7fff, 16'sd1, -16'sd1, 16'sd1);
      send_sample(16'sd100, 16'sd200, -16'sd300, 16'sd5000, -16'sd5000);
      // full-rate gyro spins the gyro term hard in one direction, then in the other
      repeat (4) send_sample('0, '0, '0, 16'sh7fff, 16'sh7fff);
      repeat (4) send_sample('0, '0, '0, 16'sh8000, 16'sh8000);
      settle();

      // register settings, reset values and extremes first; unused indexes must leave the filter alone
      run_phase(BLEND_WEIGHT_RESET, TIME_STEP_RESET);
      run_phase(16'd0, 16'hffff);       // gyro only, saturates quickly
      run_phase(16'hffff, 16'd0);       // accelerometer almost only, no integration
      run_phase(16'd0, 16'd0);          // angle frozen
      run_phase(16'hffff, 16'hffff);
      write_reg(REG_SPARE_2, CSR_DW'($urandom()));
      write_reg(REG_SPARE_3, CSR_DW'($urandom()));
      run_phase(CSR_DW'($urandom()), CSR_DW'($urandom()));
      run_phase(CSR_DW'($urandom()), CSR_DW'($urandom_range(0, 2000)));

      // all beats back; leave room for anything stray to show up
      settle();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #6_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

/* tilt_complementary_filter.f */
design/tcf_pkg.sv
design/tilt_complementary_filter.sv
sim/tcf_angle_checker.sv
sim/tb_top.sv
